// ===== design/assert_macros.svh =====
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication
`define ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication
`define ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMP(lbl, clk, rst, ante, cons)
`define ASSERT_NXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ===== design/ttk_pkg.sv =====
// Shared constants and command/status types of the tick time keeper.
`timescale 1ns / 1ps
package ttk_pkg;

   // Field and register widths
   localparam int COUNT_WIDTH = 64;
   localparam int CYCLE_W     = 64;
   localparam int TICKS_W     = 24;
   localparam int MS_W        = 10;
   localparam int TIME_W      = 32;
   localparam int DIFF_W      = 32;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 24;

   // Divider sizing: period count of a non-negative 32-bit difference
   localparam int QUOT_PER_W  = DIFF_W - 1;
   localparam int ADDED_W     = QUOT_PER_W + MS_W;
   localparam int DIVIDEND_W  = QUOT_PER_W;
   localparam int DIVISOR_W   = TICKS_W;
   localparam int STEP_W      = $clog2(DIVIDEND_W);
   localparam int DELTA_W     = DIFF_W + 3;

   // Millisecond split: twice a remainder plus one period's step stays below 4096
   localparam int MS_SUM_W    = MS_W + 2;

   localparam int MS_PER_SECOND = 1000;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TICKS_PER_PERIOD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MS_PER_PERIOD    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SKIP_MARGIN      = 2'd2;

   // Register reset values
   localparam logic [TICKS_W-1:0] TICKS_RESET  = 24'd96000;
   localparam logic [MS_W-1:0]    MS_RESET     = 10'd1;
   localparam logic [TICKS_W-1:0] MARGIN_RESET = 24'd9600;

   typedef struct packed {
      logic capture;
      logic skip_div;
      logic per_load;
      logic div_step;
      logic mul;
      logic update;
      logic delta;
      logic load_out;
   } ttk_cmd_type;

   typedef struct packed {
      logic div_ok;
      logic out_free;
   } ttk_status_type;

endpackage

// ===== design/ttk_ifs.sv =====
// Valid/ready channel interfaces for event requests and time responses.
`timescale 1ns / 1ps
interface ttk_req_if import ttk_pkg::*;;
   logic               valid;
   logic               ready;
   logic [CYCLE_W-1:0] cycle_count;

   modport source (output valid, output cycle_count, input ready);
   modport sink   (input valid, input cycle_count, output ready);
endinterface

interface ttk_rsp_if import ttk_pkg::*;;
   logic               valid;
   logic               ready;
   logic [CYCLE_W-1:0] next_compare;
   logic [TIME_W-1:0]  uptime_ms;
   logic [TIME_W-1:0]  unix_seconds;
   logic [MS_W-1:0]    ms_in_second;

   modport source (output valid, output next_compare, output uptime_ms,
                   output unix_seconds, output ms_in_second, input ready);
   modport sink   (input valid, input next_compare, input uptime_ms,
                   input unix_seconds, input ms_in_second, output ready);
endinterface

// ===== design/ttk_div.sv =====
// Restoring divider, one quotient bit per cycle while step is asserted.
`timescale 1ns / 1ps
module ttk_div import ttk_pkg::*;
(
   input  logic                  clock,
   input  logic                  load,
   input  logic                  step,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic [DIVIDEND_W-1:0] quotient,
   output logic [DIVISOR_W-1:0]  remainder,
   output logic                  quot_bit
);

   logic [DIVIDEND_W-1:0] quot_ff, quot_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  dsr_ff;
   logic [DIVISOR_W:0]    trial;
   logic                  fits;

   // Shift one dividend bit into the partial remainder, subtract if it fits
   always_comb begin
      trial   = {rem_ff, quot_ff[DIVIDEND_W-1]};
      fits    = (trial >= {1'b0, dsr_ff});
      rem_in  = fits ? DIVISOR_W'(trial - {1'b0, dsr_ff}) : trial[DIVISOR_W-1:0];
      quot_in = {quot_ff[DIVIDEND_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (load) begin
         quot_ff <= dividend;
         rem_ff  <= '0;
         dsr_ff  <= divisor;
      end else if (step) begin
         quot_ff <= quot_in;
         rem_ff  <= rem_in;
      end
   end

   assign quotient  = quot_ff;
   assign remainder = rem_ff;
   assign quot_bit  = fits;

endmodule

// ===== design/ttk_dp.sv =====
// Datapath: settings, time state, divider, next-compare math and result register.
`timescale 1ns / 1ps
module ttk_dp import ttk_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  ttk_cmd_type           cmd,
   output ttk_status_type        status,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,
   input  logic [CYCLE_W-1:0]    req_cycle_count,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [CYCLE_W-1:0]    rsp_next_compare,
   output logic [TIME_W-1:0]     rsp_uptime_ms,
   output logic [TIME_W-1:0]     rsp_unix_seconds,
   output logic [MS_W-1:0]       rsp_ms_in_second
);

   // Settings
   logic [TICKS_W-1:0] ticks_ff;
   logic [MS_W-1:0]    ms_per_ff;
   logic [TICKS_W-1:0] margin_ff;

   // Time state
   logic [COUNT_WIDTH-1:0] period_start_ff;
   logic [TIME_W-1:0]      uptime_ff;
   logic [TIME_W-1:0]      seconds_ff;
   logic [MS_W-1:0]        ms_count_ff;

   // Per-event working registers
   logic [COUNT_WIDTH-1:0]   cnt_ff;
   logic [DIFF_W-1:0]        diff_ff;
   logic signed [DIFF_W-1:0] remain_ff;
   logic [ADDED_W-1:0]       added_ff;
   logic signed [DELTA_W-1:0] delta_ff, delta_in;

   // Result register
   logic                 out_valid_ff;
   logic [CYCLE_W-1:0]   out_next_ff;
   logic [TIME_W-1:0]    out_uptime_ff;
   logic [TIME_W-1:0]    out_seconds_ff;
   logic [MS_W-1:0]      out_ms_ff;

   // Divider hookup
   logic [DIVIDEND_W-1:0] div_quot;
   logic [DIVISOR_W-1:0]  div_rem;
   logic                  div_bit;

   // Added time split into seconds and milliseconds, built one quotient bit at a time
   logic [TIME_W-1:0]   acc_s_ff, acc_s_in;
   logic [MS_W-1:0]     acc_m_ff, acc_m_in;
   logic [MS_SUM_W-1:0] acc_sum, acc_left;
   logic [1:0]          acc_carry;
   logic [MS_SUM_W-1:0] ms_sum, ms_left;
   logic                ms_wrap;

   logic [DIFF_W-1:0]         advance;
   logic signed [DELTA_W-1:0] ticks_s, margin_s, remain_s;
   logic                      skip;
   logic [COUNT_WIDTH-1:0]    next_cmp;

   // Settings writes; unknown indexes drop
   always_ff @(posedge clock) begin
      if (reset) begin
         ticks_ff  <= TICKS_RESET;
         ms_per_ff <= MS_RESET;
         margin_ff <= MARGIN_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_TICKS_PER_PERIOD: ticks_ff  <= csr_write_data[TICKS_W-1:0];
            CSR_MS_PER_PERIOD:    ms_per_ff <= csr_write_data[MS_W-1:0];
            CSR_SKIP_MARGIN:      margin_ff <= csr_write_data[TICKS_W-1:0];
            default: ;
         endcase
      end
   end

   // Elapsed count divided by the period
   ttk_div u_div (
      .clock     (clock),
      .load      (cmd.per_load),
      .step      (cmd.div_step),
      .dividend  (diff_ff[DIVIDEND_W-1:0]),
      .divisor   (ticks_ff),
      .quotient  (div_quot),
      .remainder (div_rem),
      .quot_bit  (div_bit)
   );

   // Fold each quotient bit in: double the split value, add one period's milliseconds
   always_comb begin
      acc_sum = MS_SUM_W'({acc_m_ff, 1'b0}) + (div_bit ? MS_SUM_W'(ms_per_ff) : '0);
      priority if (acc_sum >= MS_SUM_W'(3 * MS_PER_SECOND)) begin
         acc_carry = 2'd3;
         acc_left  = acc_sum - MS_SUM_W'(3 * MS_PER_SECOND);
      end else if (acc_sum >= MS_SUM_W'(2 * MS_PER_SECOND)) begin
         acc_carry = 2'd2;
         acc_left  = acc_sum - MS_SUM_W'(2 * MS_PER_SECOND);
      end else if (acc_sum >= MS_SUM_W'(MS_PER_SECOND)) begin
         acc_carry = 2'd1;
         acc_left  = acc_sum - MS_SUM_W'(MS_PER_SECOND);
      end else begin
         acc_carry = 2'd0;
         acc_left  = acc_sum;
      end
      acc_m_in = acc_left[MS_W-1:0];
      acc_s_in = {acc_s_ff[TIME_W-2:0], 1'b0} + TIME_W'(acc_carry);
      // Merge the added milliseconds with the running count
      ms_sum  = MS_SUM_W'(ms_count_ff) + MS_SUM_W'(acc_m_ff);
      ms_wrap = (ms_sum >= MS_SUM_W'(MS_PER_SECOND));
      ms_left = ms_wrap ? ms_sum - MS_SUM_W'(MS_PER_SECOND) : ms_sum;
   end

   // Split register: clear on divider load, fold on each step
   always_ff @(posedge clock) begin
      if (cmd.per_load) begin
         acc_s_ff <= '0;
         acc_m_ff <= '0;
      end else if (cmd.div_step) begin
         acc_s_ff <= acc_s_in;
         acc_m_ff <= acc_m_in;
      end
   end

   // Skip test and compare distance
   always_comb begin
      advance  = diff_ff - remain_ff;
      ticks_s  = $signed({{(DELTA_W-TICKS_W){1'b0}}, ticks_ff});
      margin_s = $signed({{(DELTA_W-TICKS_W){1'b0}}, margin_ff});
      remain_s = DELTA_W'(remain_ff);
      skip     = (remain_s >= (ticks_s - margin_s));
      delta_in = ticks_s - remain_s + (skip ? ticks_s : '0);
      next_cmp = cnt_ff + COUNT_WIDTH'(delta_ff);
   end

   // Event working registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cnt_ff  <= req_cycle_count[COUNT_WIDTH-1:0];
         diff_ff <= req_cycle_count[DIFF_W-1:0] - period_start_ff[DIFF_W-1:0];
      end
      if (cmd.skip_div) begin
         remain_ff <= diff_ff;
      end
      if (cmd.mul) begin
         added_ff  <= ADDED_W'(div_quot[QUOT_PER_W-1:0]) * ADDED_W'(ms_per_ff);
         remain_ff <= DIFF_W'(div_rem);
      end
      if (cmd.delta) begin
         delta_ff <= delta_in;
      end
   end

   // Time state: advance by whole periods
   always_ff @(posedge clock) begin
      if (reset) begin
         period_start_ff <= '0;
         uptime_ff       <= '0;
         seconds_ff      <= '0;
         ms_count_ff     <= '0;
      end else if (cmd.update) begin
         period_start_ff <= period_start_ff + COUNT_WIDTH'(advance);
         uptime_ff       <= uptime_ff + added_ff[TIME_W-1:0];
         seconds_ff      <= seconds_ff + acc_s_ff + TIME_W'(ms_wrap);
         ms_count_ff     <= ms_left[MS_W-1:0];
      end
   end

   // Result register: hold until the transfer completes
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_next_ff    <= CYCLE_W'(next_cmp);
         out_uptime_ff  <= uptime_ff;
         out_seconds_ff <= seconds_ff;
         out_ms_ff      <= ms_count_ff;
      end
   end

   assign status.div_ok   = !diff_ff[DIFF_W-1] && (ticks_ff != '0);
   assign status.out_free = !out_valid_ff || rsp_ready;

   assign rsp_valid        = out_valid_ff;
   assign rsp_next_compare = out_next_ff;
   assign rsp_uptime_ms    = out_uptime_ff;
   assign rsp_unix_seconds = out_seconds_ff;
   assign rsp_ms_in_second = out_ms_ff;

endmodule

// ===== design/ttk_ctrl.sv =====
// Controller: sequences capture, the period division, the update and the result load.
`timescale 1ns / 1ps
module ttk_ctrl import ttk_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  ttk_status_type status,
   output ttk_cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_CHECK   = 3'd1;
   localparam logic [2:0] ST_DIV_PER = 3'd2;
   localparam logic [2:0] ST_MUL     = 3'd3;
   localparam logic [2:0] ST_UPDATE  = 3'd4;
   localparam logic [2:0] ST_DELTA   = 3'd5;
   localparam logic [2:0] ST_LOAD    = 3'd6;

   localparam logic [STEP_W-1:0] PER_LAST = STEP_W'(QUOT_PER_W - 1);

   logic [2:0]        state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_CHECK;
            end
         end
         // Negative difference or zero period: no time advances
         ST_CHECK: begin
            if (status.div_ok) begin
               cmd.per_load = 1'b1;
               step_in      = PER_LAST;
               state_in     = ST_DIV_PER;
            end else begin
               cmd.skip_div = 1'b1;
               state_in     = ST_DELTA;
            end
         end
         ST_DIV_PER: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff - 1'b1;
            if (step_ff == '0) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_DELTA;
         end
         ST_DELTA: begin
            cmd.delta = 1'b1;
            state_in  = ST_LOAD;
         end
         // Wait for the result register to free up
         ST_LOAD: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

// ===== design/tick_time_keeper.sv =====
// Top level of the tick time keeper: controller, datapath and checks.
//
//  channel | dir | handshake     | payload
//  req     | in  | valid/ready   | cycle_count
//  rsp     | out | valid/ready   | next_compare, uptime_ms, unix_seconds, ms_in_second
//  csr     | in  | write enable  | csr_index, csr_write_data
//
// One event at a time; the result is offered after the check, the restoring-divider
// steps for the period count, multiply, update, delta and load, or after the check,
// delta and load alone with a negative difference or a zero period. Synchronous
// reset clears the time state, loads the setting defaults and empties the result
// register. Idle takes the next event even while the last result waits; a stalled
// result then holds the controller in its load step and the input stalls.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tick_time_keeper import ttk_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   ttk_req_if.sink               req,
   ttk_rsp_if.source             rsp,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   ttk_cmd_type    cmd;
   ttk_status_type status;

   ttk_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .status    (status),
      .cmd       (cmd)
   );

   ttk_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_cycle_count  (req.cycle_count),
      .rsp_valid        (rsp.valid),
      .rsp_ready        (rsp.ready),
      .rsp_next_compare (rsp.next_compare),
      .rsp_uptime_ms    (rsp.uptime_ms),
      .rsp_unix_seconds (rsp.unix_seconds),
      .rsp_ms_in_second (rsp.ms_in_second)
   );

   // Busy after an accepted event
   `ASSERT_NXT(a_busy_after_accept, clock, reset, req.valid && req.ready, !req.ready)
   // Never overwrite a result that has not been transferred
   `ASSERT_IMP(a_no_overwrite, clock, reset, cmd.load_out, !rsp.valid || rsp.ready)
   // Millisecond field stays within one second
   `ASSERT_IMP(a_ms_range, clock, reset, rsp.valid, rsp.ms_in_second < 10'd1000)
   // A divider load is followed by stepping
   `ASSERT_NXT(a_step_after_load, clock, reset, cmd.per_load, cmd.div_step)

endmodule

// ===== dv/tick_time_keeper_checker.sv =====
// Checker for the tick time keeper: predicts each time report and compares it on transfer.
`timescale 1ns / 1ps
module tick_time_keeper_checker import ttk_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   ttk_req_if                    req,
   ttk_rsp_if                    rsp,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,
   output int                    mismatch_count,
   output int                    outstanding
);

   typedef struct packed {
      logic [CYCLE_W-1:0] next_compare;
      logic [TIME_W-1:0]  uptime_ms;
      logic [TIME_W-1:0]  unix_seconds;
      logic [MS_W-1:0]    ms_in_second;
   } time_report_type;

   // Settings as the block holds them
   logic [TICKS_W-1:0] period_len;
   logic [MS_W-1:0]    ms_step;
   logic [TICKS_W-1:0] margin;

   // Time state
   logic [COUNT_WIDTH-1:0] period_start;
   logic [TIME_W-1:0]      uptime;
   logic [TIME_W-1:0]      seconds;
   logic [MS_W-1:0]        ms_part;

   time_report_type expected_reports[$];
   int              errors = 0;

   assign mismatch_count = errors;

   // Apply all elapsed periods of one event and form the next compare value.
   function automatic time_report_type apply_event(logic [CYCLE_W-1:0] cycle_count);
      logic [63:0]     mask;
      logic [63:0]     cnt;
      logic [31:0]     raw;
      longint          diff;
      longint          remain;
      longint unsigned tk;
      longint unsigned periods;
      longint unsigned added_ms;
      longint unsigned total_ms;
      longint unsigned carry_s;
      longint unsigned left_ms;
      logic [63:0]     next_cmp;
      time_report_type rep;
      mask = {64{1'b1}} >> (64 - COUNT_WIDTH);
      cnt  = cycle_count & mask;
      tk   = 64'(period_len);
      raw  = cnt[31:0] - period_start[31:0];
      diff = {{32{raw[31]}}, raw};
      periods = 0;
      if (diff >= 0 && tk != 0) begin
         periods = $unsigned(diff) / tk;
      end
      remain = diff - $signed(periods * tk);
      if (periods != 0) begin
         added_ms     = periods * longint'(ms_step);
         total_ms     = longint'(ms_part) + added_ms;
         carry_s      = total_ms / MS_PER_SECOND;
         left_ms      = total_ms % MS_PER_SECOND;
         period_start = (period_start + periods * tk) & mask;
         uptime       = uptime + added_ms[TIME_W-1:0];
         seconds      = seconds + carry_s[TIME_W-1:0];
         ms_part      = left_ms[MS_W-1:0];
      end
      next_cmp = cnt + $unsigned($signed(tk) - remain);
      // skip one period when too little of the current one is left
      if (remain >= $signed(tk) - longint'(margin)) begin
         next_cmp = next_cmp + tk;
      end
      rep.next_compare = next_cmp & mask;
      rep.uptime_ms    = uptime;
      rep.unix_seconds = seconds;
      rep.ms_in_second = ms_part;
      return rep;
   endfunction

   task automatic report_mismatch(string what, time_report_type got, time_report_type want);
      errors++;
      $display("%0t: %s: got %h/%h/%h/%h, expected %h/%h/%h/%h", $time, what,
               got.next_compare, got.uptime_ms, got.unix_seconds, got.ms_in_second,
               want.next_compare, want.uptime_ms, want.unix_seconds, want.ms_in_second);
   endtask

   always @(posedge clock) begin
      time_report_type got;
      time_report_type want;
      if (reset) begin
         period_len   = TICKS_RESET;
         ms_step      = MS_RESET;
         margin       = MARGIN_RESET;
         period_start = '0;
         uptime       = '0;
         seconds      = '0;
         ms_part      = '0;
         expected_reports.delete();
      end else begin
         // Compare a result transfer with the oldest prediction
         if (rsp.valid && rsp.ready) begin
            got.next_compare = rsp.next_compare;
            got.uptime_ms    = rsp.uptime_ms;
            got.unix_seconds = rsp.unix_seconds;
            got.ms_in_second = rsp.ms_in_second;
            if (expected_reports.size() == 0) begin
               report_mismatch("result with none expected", got, '0);
            end else begin
               want = expected_reports.pop_front();
               if (got.next_compare !== want.next_compare ||
                   got.uptime_ms !== want.uptime_ms ||
                   got.unix_seconds !== want.unix_seconds ||
                   got.ms_in_second !== want.ms_in_second) begin
                  report_mismatch("result differs", got, want);
               end
            end
         end
         // Predict each accepted event
         if (req.valid && req.ready) begin
            expected_reports.push_back(apply_event(req.cycle_count));
         end
         // Track setting writes; unknown indexes are dropped
         if (csr_write_en) begin
            case (csr_index)
               CSR_TICKS_PER_PERIOD: period_len = csr_write_data[TICKS_W-1:0];
               CSR_MS_PER_PERIOD:    ms_step    = csr_write_data[MS_W-1:0];
               CSR_SKIP_MARGIN:      margin     = csr_write_data[TICKS_W-1:0];
               default: ;
            endcase
         end
      end
      outstanding <= expected_reports.size();
   end

endmodule

// ===== dv/tick_time_keeper_tb.sv =====
// Testbench top for the tick time keeper: clock, reset, event stimulus, settings and verdict.
`timescale 1ns / 1ps
module tick_time_keeper_tb;
   import ttk_pkg::*;

   localparam int CLOCK_HALF      = 5;
   localparam int RESET_CYCLES    = 7;
   localparam int CYCLE_LIMIT     = 600000;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int SETTLE_CYCLES   = 100;
   localparam int IDLE_GUARD      = 10;
   localparam int RANDOM_PHASES   = 7;
   localparam int ITEMS_PER_PHASE = 80;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   typedef enum int {STEP_IN_PERIOD, STEP_BACKWARD, STEP_FAR, STEP_ANY} step_kind_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_write_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   ttk_req_if req_ch();
   ttk_rsp_if rsp_ch();

   int mismatch_count;
   int outstanding;
   int cycle_total = 0;

   logic               sender_gaps     = 1'b0;
   logic               receiver_stalls = 1'b0;
   logic               hold_off_req    = 1'b0;
   logic [CYCLE_W-1:0] last_count;
   logic [TICKS_W-1:0] cur_ticks;

   tick_time_keeper uut (
      .clock          (clock),
      .reset          (reset),
      .req            (req_ch),
      .rsp            (rsp_ch),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   tick_time_keeper_checker time_check (
      .clock          (clock),
      .reset          (reset),
      .req            (req_ch),
      .rsp            (rsp_ch),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #CLOCK_HALF clock = ~clock;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_total <= cycle_total + 1;
      if (cycle_total >= CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Result side: random stall bursts, plus one long hold-off on request
   initial begin
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_req) begin
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            hold_off_req = 1'b0;
         end else if (receiver_stalls && $urandom_range(0, 5) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // Offer one event and hold it until the transfer; maybe idle afterwards
   task automatic send_event(logic [CYCLE_W-1:0] count);
      req_ch.valid       <= 1'b1;
      req_ch.cycle_count <= count;
      last_count = count;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      if (sender_gaps && $urandom_range(0, 4) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   // Drop valid and wait until every predicted result has been taken
   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (IDLE_GUARD) @(posedge clock);
   endtask

   task automatic put_reg(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
      csr_write_en   <= 1'b1;
      csr_index      <= index;
      csr_write_data <= data;
      @(posedge clock);
   endtask

   // Write all settings once the block is idle; stray index and upper ms bits ride along
   task automatic write_settings(logic [TICKS_W-1:0] ticks, logic [MS_W-1:0] ms,
                                 logic [TICKS_W-1:0] margin);
      logic [CSR_DATA_W-1:0] ms_word;
      wait_idle();
      ms_word = CSR_DATA_W'($urandom);
      ms_word[MS_W-1:0] = ms;
      put_reg(CSR_UNUSED, CSR_DATA_W'($urandom));
      put_reg(CSR_TICKS_PER_PERIOD, ticks);
      put_reg(CSR_MS_PER_PERIOD, ms_word);
      put_reg(CSR_SKIP_MARGIN, margin);
      csr_write_en <= 1'b0;
      @(posedge clock);
      cur_ticks = ticks;
   endtask

   function automatic step_kind_type pick_kind();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 70) return STEP_IN_PERIOD;
      if (r < 82) return STEP_BACKWARD;
      if (r < 92) return STEP_FAR;
      return STEP_ANY;
   endfunction

   // Next counter value relative to the last event
   function automatic logic [CYCLE_W-1:0] pick_count(step_kind_type kind);
      int unsigned        span;
      logic [CYCLE_W-1:0] count;
      span = (cur_ticks == 0) ? 100000 : cur_ticks;
      case (kind)
         STEP_IN_PERIOD:
            count = last_count + 64'($urandom_range(0, 3)) * span + $urandom_range(0, span - 1);
         STEP_BACKWARD:
            count = last_count - $urandom_range(1, span + 100000);
         STEP_FAR:
            count = last_count + {32'd0, $urandom};
         default:
            count = {$urandom, $urandom};
      endcase
      return count;
   endfunction

   initial begin
      logic [TICKS_W-1:0] ticks;
      logic [MS_W-1:0]    ms;
      logic [TICKS_W-1:0] margin;
      reset              <= 1'b1;
      req_ch.valid       <= 1'b0;
      req_ch.cycle_count <= '0;
      csr_write_en       <= 1'b0;
      csr_index          <= '0;
      csr_write_data     <= '0;
      last_count = '0;
      cur_ticks  = TICKS_RESET;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      sender_gaps     = 1'b1;
      receiver_stalls = 1'b1;

      // Reset settings, period start at zero
      send_event(64'h0000_0000_8000_0000);     // most negative difference
      send_event(64'hFFFF_FFFF_FFFF_FFFF);     // difference of minus one, next compare wraps
      send_event(64'd0);
      send_event(64'd95999);                   // inside the first period, inside the margin
      send_event(64'd96000);                   // exactly one period
      send_event(64'd470399);                  // three periods, just clear of the margin
      send_event(64'd566400);                  // one period, right on the margin
      send_event(64'd366400);                  // counter went backward
      send_event(64'd480000 + 64'h7FFF_FFFF);  // largest positive difference

      // One count per period and a full second each: counters wrap
      write_settings(24'd1, 10'd1000, 24'd0);
      send_event(last_count);
      repeat (4) send_event(last_count + 64'h7FFF_FFFF);

      // Zero period advances nothing
      write_settings(24'd0, 10'd5, 24'd100);
      send_event(last_count + 64'd12345);
      send_event(last_count - 64'd7);

      // Widest period, millisecond step past one second, margin equal to period
      write_settings(24'hFF_FFFF, 10'd1023, 24'hFF_FFFF);
      send_event(last_count + 64'd50_000_000);
      send_event(last_count + 64'd16_777_214);
      send_event(last_count + 64'h7FFF_FFFF);

      // Margin beyond the period, no milliseconds per period
      write_settings(24'd1000, 10'd0, 24'd2500);
      send_event(last_count + 64'd3500);
      send_event(last_count + 64'd999);

      // Random settings and events; the last phase runs without idling
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case ($urandom_range(0, 4))
            0:       ticks = TICKS_W'($urandom_range(1, 16));
            1:       ticks = TICKS_W'($urandom_range(17, 5000));
            2:       ticks = TICKS_W'($urandom_range(5001, 200000));
            3:       ticks = TICKS_W'($urandom_range(200001, 24'hFF_FFFF));
            default: ticks = TICKS_RESET;
         endcase
         ms     = MS_W'($urandom_range(0, 1023));
         margin = TICKS_W'($urandom_range(0, 1) ? $urandom_range(0, ticks) : $urandom);
         write_settings(ticks, ms, margin);
         sender_gaps     = (phase < RANDOM_PHASES - 1) && ($urandom_range(0, 3) != 0);
         receiver_stalls = (phase < RANDOM_PHASES - 1) && ($urandom_range(0, 3) != 0);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (phase == 1 && n == 20) begin
               hold_off_req = 1'b1;
            end
            if (phase == 2 && n == 40) begin
               wait_idle();
            end
            send_event(pick_count(pick_kind()));
         end
      end

      // Drain, then allow for late or stray results
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+design
design/ttk_pkg.sv
design/ttk_ifs.sv
design/ttk_div.sv
design/ttk_dp.sv
design/ttk_ctrl.sv
design/tick_time_keeper.sv
dv/tick_time_keeper_checker.sv
dv/tick_time_keeper_tb.sv
